// File: src/rne_pkg.sv
package rne_pkg;

	localparam int ValueW = 13;
	localparam int SymW   = 7;
	localparam int Terms  = 13;
	localparam int TermW  = $clog2(Terms);

	// Inputs of this value and above are out of range
	localparam logic [ValueW-1:0] Limit = ValueW'(5000);

	// Default depth of the queue between front and back
	localparam int QueueDepthDef = 2;

	localparam logic [SymW-1:0] SymNone = 7'h00;
	localparam logic [SymW-1:0] SymM    = 7'h4D;
	localparam logic [SymW-1:0] SymD    = 7'h44;
	localparam logic [SymW-1:0] SymC    = 7'h43;
	localparam logic [SymW-1:0] SymL    = 7'h4C;
	localparam logic [SymW-1:0] SymX    = 7'h58;
	localparam logic [SymW-1:0] SymV    = 7'h56;
	localparam logic [SymW-1:0] SymI    = 7'h49;

	localparam logic [ValueW-1:0] Weight [Terms] = '{
		13'd1000, 13'd900, 13'd500, 13'd400, 13'd100, 13'd90, 13'd50,
		13'd40, 13'd10, 13'd9, 13'd5, 13'd4, 13'd1
	};

	localparam logic [SymW-1:0] FirstSym [Terms] = '{
		SymM, SymC, SymD, SymC, SymC, SymX, SymL, SymX, SymX, SymI, SymV, SymI, SymI
	};

	// SymNone: the term is a single letter
	localparam logic [SymW-1:0] SecondSym [Terms] = '{
		SymNone, SymM, SymNone, SymD, SymNone, SymC, SymNone, SymL, SymNone,
		SymX, SymNone, SymV, SymNone
	};

	// One classified item as it travels from front to back
	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              err;
	} item_t;

endpackage

// File: src/rne_front.sv
module rne_front (
	input  logic [rne_pkg::ValueW-1:0] value,
	output rne_pkg::item_t             item
);

	// Flag zero and anything at or above the limit
	always_comb begin
		item.value = value;
		item.err   = (value == '0) || (value >= rne_pkg::Limit);
	end

endmodule

// File: src/rne_queue.sv
module rne_queue #(
	parameter int Depth = rne_pkg::QueueDepthDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rne_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output rne_pkg::item_t pop_item
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	rne_pkg::item_t  entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(Depth));
	assign avail    = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail)
		else $error("pop from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");
`endif

endmodule

// File: src/rne_back.sv
module rne_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       avail,
	input  rne_pkg::item_t             item,
	output logic                       pop,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [rne_pkg::SymW-1:0]   symbol,
	output logic                       error,
	output logic                       last
);

	logic                        busy_q;
	logic                        err_q;
	logic                        pend_q;
	logic [rne_pkg::SymW-1:0]    pend_sym_q;
	logic [rne_pkg::ValueW-1:0]  num_q;

	logic                        out_valid_q;
	logic [rne_pkg::SymW-1:0]    symbol_q;
	logic                        error_q;
	logic                        last_q;

	logic                        emit;
	logic [rne_pkg::TermW-1:0]   sel;
	logic [rne_pkg::ValueW-1:0]  rem;
	logic [rne_pkg::SymW-1:0]    sym_d;
	logic                        last_d;

	assign emit = busy_q && (!out_valid_q || !rsp_stall);
	assign pop  = !busy_q && avail;

	// Largest weight that fits; greedy order makes this the right term
	always_comb begin
		sel = rne_pkg::TermW'(rne_pkg::Terms - 1);
		for (int t = rne_pkg::Terms - 1; t >= 0; t--) begin
			if (num_q >= rne_pkg::Weight[t]) begin
				sel = rne_pkg::TermW'(t);
			end
		end
		rem = num_q - rne_pkg::Weight[sel];
		if (pend_q) begin
			sym_d  = pend_sym_q;
			last_d = (num_q == '0);
		end else if (err_q) begin
			sym_d  = rne_pkg::SymNone;
			last_d = 1'b1;
		end else begin
			sym_d  = rne_pkg::FirstSym[sel];
			last_d = (rem == '0) && (rne_pkg::SecondSym[sel] == rne_pkg::SymNone);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (emit) begin
				if (last_d) begin
					busy_q <= 1'b0;
				end
				if (pend_q) begin
					pend_q <= 1'b0;
				end else if (!err_q) begin
					pend_q <= (rne_pkg::SecondSym[sel] != rne_pkg::SymNone);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q <= item.value;
			err_q <= item.err;
		end else if (emit && !pend_q && !err_q) begin
			num_q      <= rem;
			pend_sym_q <= rne_pkg::SecondSym[sel];
		end
		if (emit) begin
			symbol_q <= sym_d;
			error_q  <= err_q && !pend_q;
			last_q   <= last_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign error     = error_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> last_q && symbol_q == rne_pkg::SymNone)
		else $error("error beat is not a lone final beat");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> busy_q && !err_q)
		else $error("second letter pending outside a valid run");

	a_num_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !pend_q && !err_q |-> num_q != '0)
		else $error("run active with nothing left to encode");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy_q)
		else $error("item taken from queue but back not busy");
`endif

endmodule

// File: src/roman_numeral_encoder_core.sv
// Roman numeral encoder: takes one 13-bit integer per req beat and emits its
// numeral as ASCII letters, one rsp beat per letter, with last set on the
// final letter. Encoding is greedy over 1000, 900, 500, 400, 100, 90, 50, 40,
// 10, 9, 5, 4 and 1, so values up to 4999 encode (four leading M allowed);
// the longest run is 16 letters, for 4888. Zero and anything from 5000 up
// give a single beat with symbol 0, error 1 and last 1. A front stage
// classifies each value and pushes it into a short queue (QueueDepth
// entries); the back stage pops one item, loads it and then emits one letter
// per cycle while the output is not stalled; it pops no new item until the
// last letter of the run is emitted. The single-letter emitter in the back
// stage sets the throughput; the queue lets the front keep taking beats while
// a run is in progress. The output is registered, and a letter stalled there
// holds the back stage: no further letter is emitted until it is taken.
module roman_numeral_encoder_core #(
	parameter int QueueDepth = rne_pkg::QueueDepthDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [rne_pkg::ValueW-1:0] value,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [rne_pkg::SymW-1:0]  symbol,
	output logic                      error,
	output logic                      last
);

	rne_pkg::item_t front_item;
	rne_pkg::item_t queue_item;
	logic           queue_full;
	logic           queue_avail;
	logic           queue_pop;
	logic           push;

	// Stall the request side only while the queue is full
	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full;

	// Classify: flag out-of-range values before they are queued
	rne_front u_front (
		.value (value),
		.item  (front_item)
	);

	// Decouple: hold classified items until the back is free
	rne_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.avail     (queue_avail),
		.pop_item  (queue_item)
	);

	// Encode: one letter per cycle into the output register while the output is not stalled
	rne_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (queue_avail),
		.item      (queue_item),
		.pop       (queue_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.symbol    (symbol),
		.error     (error),
		.last      (last)
	);

endmodule

// File: verif/tb_roman_numeral_encoder_core.sv
`timescale 1ns / 100ps

module tb_roman_numeral_encoder_core;

	localparam int VW = rne_pkg::ValueW;
	localparam int SW = rne_pkg::SymW;

	// First value that no longer encodes (four M is the most allowed)
	localparam int unsigned NumeralCeiling = 5000;

	// Greedy terms, largest first, each with its one or two letters. A
	// single-letter term leaves the upper byte clear.
	localparam int unsigned TermCount = 13;
	localparam int unsigned TermWeight [TermCount] = '{
		1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
	};
	localparam logic [15:0] TermLetters [TermCount] = '{
		"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX", "V", "IV", "I"
	};

	typedef struct {
		logic [SW-1:0] symbol;
		logic          error;
		logic          last;
	} letter_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	logic [VW-1:0] value     = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	logic [SW-1:0] symbol;
	logic          error;
	logic          last;

	// Letters still owed by the block, oldest first
	letter_t letters_due [$];

	int faults        = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// Cycles left in a forced receiver hold-off
	int hold_cycles   = 0;

	roman_numeral_encoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.symbol    (symbol),
		.error     (error),
		.last      (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Spell one value as the run of letters the block must emit, and queue
	// them. Zero and anything from the ceiling up give a lone error beat.
	function automatic void spell_numeral(input logic [VW-1:0] num);
		int unsigned rest;
		letter_t beat;
		letter_t run_q [$];
		rest = 32'(num);
		beat.error = 1'b0;
		beat.last  = 1'b0;
		if (num == 0 || num >= NumeralCeiling) begin
			beat.symbol = '0;
			beat.error  = 1'b1;
			beat.last   = 1'b1;
			letters_due.push_back(beat);
			return;
		end
		for (int t = 0; t < TermCount; t++) begin
			while (rest >= TermWeight[t]) begin
				rest -= TermWeight[t];
				// two-letter terms put the smaller letter first (CM, XC, IV ...)
				if (TermLetters[t][15:8] != 8'd0) begin
					beat.symbol = TermLetters[t][14:8];
					run_q.push_back(beat);
				end
				beat.symbol = TermLetters[t][6:0];
				run_q.push_back(beat);
			end
		end
		run_q[run_q.size() - 1].last = 1'b1;
		foreach (run_q[i])
			letters_due.push_back(run_q[i]);
	endfunction

	// Pick a value: mostly in range, a share of error values, and a share
	// built digit by digit with many 8s to get long runs.
	function automatic logic [VW-1:0] pick_value();
		int unsigned th, hu, te, un;
		case ($urandom_range(9))
			0: return '0;
			1: return VW'($urandom_range(8191, NumeralCeiling));
			2, 3: begin
				th = $urandom_range(4);
				hu = $urandom_range(1) ? 8 : $urandom_range(9);
				te = $urandom_range(1) ? 8 : $urandom_range(9);
				un = $urandom_range(1) ? 8 : $urandom_range(9);
				return VW'(th * 1000 + hu * 100 + te * 10 + un);
			end
			default: return VW'($urandom_range(NumeralCeiling - 1, 1));
		endcase
	endfunction

	// Offer one value and hold it until the block takes it. Valid is left
	// high afterwards so that back-to-back beats need no second assignment
	// in the same step; the next call or the end of the run drops it.
	task automatic send_value(input logic [VW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		value     <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		spell_numeral(v);
	endtask

	// Receiver: a forced hold-off wins, otherwise stall at the phase's rate
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare every accepted beat with the oldest letter owed
	always @(posedge clk) begin
		letter_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (letters_due.size() == 0) begin
				$error("beat with nothing owed: symbol %0h error %0b last %0b",
					symbol, error, last);
				faults++;
			end else begin
				want = letters_due.pop_front();
				if (symbol !== want.symbol) begin
					$error("symbol: expected %0h, got %0h", want.symbol, symbol);
					faults++;
				end
				if (error !== want.error) begin
					$error("error: expected %0b, got %0b", want.error, error);
					faults++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					faults++;
				end
			end
		end
	end

	task automatic random_burst(input int count);
		repeat (count)
			send_value(pick_value());
	endtask

	// Edges of the range, every term on its own, the longest run, and the
	// error values at zero, the ceiling and the top of the field
	task automatic test_directed_values();
		int unsigned picks [$];
		picks = '{1, 4, 5, 9, 10, 40, 50, 90, 100, 400, 500, 900, 1000, 3,
			3999, 4000, 4888, 4999, 1994, 2749, 0, 5000, 8191, 6826, 4096};
		send_idle_pct = 0;
		stall_pct     = 0;
		foreach (picks[i])
			send_value(VW'(picks[i]));
	endtask

	task automatic test_random_no_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
		random_burst(16);
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct = 48;
		stall_pct     = 0;
		random_burst(16);
	endtask

	task automatic test_random_receiver_stalls();
		send_idle_pct = 0;
		stall_pct     = 48;
		random_burst(16);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct = 28;
		stall_pct     = 28;
		random_burst(16);
	endtask

	// Hold the receiver off for a long stretch while values keep coming, so
	// the queue fills and the block has to stall its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 300;
		random_burst(12);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_values();
		test_random_no_idle();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();
		test_backpressure();

		// drop valid, let the owed letters drain, then allow a tail
		req_valid     <= 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		for (int i = 0; i < 20000 && letters_due.size() != 0; i++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (letters_due.size() != 0) begin
			$error("%0d letters never arrived", letters_due.size());
			faults++;
		end

		if (faults == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
